// ----- sv/q4brd_pkg.sv -----
// Shared constants, types and helper functions for the Q4 block row dot unit.
// Depends on nothing; every other file of the unit imports it.
`default_nettype none

package q4brd_pkg;

   localparam int BLOCK_LEN  = 32;
   localparam int NUM_LANES  = 4;
   localparam int LANE_LEN   = BLOCK_LEN / NUM_LANES;
   localparam int NIB_W      = 4;
   localparam int ACT_W      = 8;
   localparam int NIB_BIAS   = 8;
   localparam int PART_W     = 15;   // signed sum of eight 4b x 8b products
   localparam int DOT_W      = 17;   // signed sum of four lane partials
   localparam int DMAG_W     = 16;   // magnitude of the block dot product
   localparam int SIG_W      = 24;   // fp32 significand with hidden bit
   localparam int HSIG_W     = 11;   // fp16 significand with hidden bit
   localparam int PMAG_W     = SIG_W + DMAG_W;
   localparam int WIN_W      = 80;   // alignment window of the adder
   localparam int MAG_W      = WIN_W + 1;
   localparam int EXP_W      = 12;
   localparam int SHIFT_MAX  = 127;

   localparam int F32_BIAS_LSB = 150;   // lsb exponent of a normal fp32 is field - 150
   localparam int F32_MIN_LSB  = -149;
   localparam int F16_BIAS_LSB = 25;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [30:0] F32_INF   = 31'h7F80_0000;
   localparam logic [7:0]  F32_EMAX  = 8'hFF;
   localparam logic [4:0]  F16_EMAX  = 5'h1F;

   typedef logic signed [EXP_W-1:0] exp_type;

   // one request to the normalise and round unit: value is mag * 2^lsb
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      exp_type          lsb;
      logic             sign;
   } rnd_req_type;

   // count leading zeros of the adder result, MAG_W when all zero
   function automatic logic [6:0] lzc81(input logic [MAG_W-1:0] v);
      logic [6:0] n;
      n = 7'(MAG_W);
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) n = 7'(MAG_W - 1 - i);
      end
      return n;
   endfunction

   // count leading zeros of a significand-sized word
   function automatic logic [4:0] lzc24(input logic [SIG_W-1:0] v);
      logic [4:0] n;
      n = 5'(SIG_W);
      for (int i = 0; i < SIG_W; i++) begin
         if (v[i]) n = 5'(SIG_W - 1 - i);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- sv/q4brd_lane.sv -----
// One dot-product lane: eight 4-bit weights times eight int8 activations, summed and registered.
// Depends on q4brd_pkg.
`default_nettype none

module q4brd_lane (
   input  wire logic                                           clock,
   input  wire logic                                           load,
   input  wire logic [q4brd_pkg::NIB_W*q4brd_pkg::LANE_LEN-1:0] nibbles,
   input  wire logic [q4brd_pkg::ACT_W*q4brd_pkg::LANE_LEN-1:0] acts,
   output logic signed [q4brd_pkg::PART_W-1:0]                  partial
);
   import q4brd_pkg::*;

   logic signed [PART_W-1:0] partial_ff;
   logic signed [PART_W-1:0] partial_in;

   // remove the nibble offset, multiply and sum the eight elements
   always_comb begin
      logic signed [NIB_W:0]   w;
      logic signed [ACT_W-1:0] x;
      logic signed [12:0]      prod;
      partial_in = '0;
      for (int j = 0; j < LANE_LEN; j++) begin
         w    = $signed({1'b0, nibbles[NIB_W*j +: NIB_W]}) - signed'(5'(NIB_BIAS));
         x    = $signed(acts[ACT_W*j +: ACT_W]);
         prod = w * x;
         partial_in = partial_in + PART_W'(prod);
      end
   end

   // hold the lane sum for the merge step
   always_ff @(posedge clock) begin
      if (load) partial_ff <= partial_in;
   end

   assign partial = partial_ff;

endmodule

`default_nettype wire

// ----- sv/q4brd_round.sv -----
// Normalise and round unit: turns mag * 2^lsb into an fp32 pattern, nearest-even.
// Depends on q4brd_pkg.
`default_nettype none

module q4brd_round (
   input  wire logic                   clock,
   input  wire logic                   go,
   input  wire q4brd_pkg::rnd_req_type req,
   output logic [31:0]                 result
);
   import q4brd_pkg::*;

   localparam int Z_W = MAG_W + 25;

   logic [MAG_W-1:0] mag_ff;
   logic [6:0]       u_ff, u_in;
   logic [8:0]       tb_ff, tb_in;
   logic             sign_ff, zero_ff, zero_in;
   logic [31:0]      result_ff, result_in;

   // find the leading one and the lsb exponent of the rounded result
   always_comb begin
      logic [6:0] lz;
      exp_type    elead;
      exp_type    target;
      exp_type    ku;
      lz     = lzc81(req.mag);
      elead  = req.lsb + exp_type'(MAG_W - 1) - exp_type'({5'b0, lz});
      target = elead - exp_type'(SIG_W - 1);
      if (target < exp_type'(F32_MIN_LSB)) target = exp_type'(F32_MIN_LSB);
      ku     = target - req.lsb + exp_type'(SIG_W - 1);
      u_in   = (ku > exp_type'(SHIFT_MAX)) ? 7'(SHIFT_MAX) : ku[6:0];
      tb_in  = 9'(target - exp_type'(F32_MIN_LSB));
      zero_in = (req.mag == '0);
   end

   // shift to the target lsb, round to nearest-even and pack
   always_comb begin
      logic [Z_W-1:0]   z;
      logic [Z_W-1:0]   q;
      logic [Z_W-1:0]   mask;
      logic [SIG_W-1:0] sig;
      logic             guard, sticky, inc;
      logic [SIG_W:0]   sig_r;
      logic [32:0]      val;
      z      = {mag_ff, 25'b0};
      q      = z >> u_ff;
      mask   = ~({Z_W{1'b1}} << u_ff);
      sig    = q[SIG_W+1:2];
      guard  = q[1];
      sticky = q[0] | (|(z & mask));
      inc    = guard & (sticky | sig[0]);
      sig_r  = {1'b0, sig} + (SIG_W+1)'(inc);
      val    = {1'b0, tb_ff, 23'b0} + 33'(sig_r);
      if (zero_ff) begin
         result_in = {sign_ff, 31'b0};
      end else if (val >= {2'b0, F32_INF}) begin
         result_in = {sign_ff, F32_INF};
      end else begin
         result_in = {sign_ff, val[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         mag_ff  <= req.mag;
         u_ff    <= u_in;
         tb_ff   <= tb_in;
         sign_ff <= req.sign;
         zero_ff <= zero_in;
      end
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ----- sv/q4_block_row_dot_unit.sv -----
// Q4 block row dot unit: top level with sequencer, lane merge, scale product and fused add.
// Depends on q4brd_pkg, q4brd_lane and q4brd_round.
//
// Each transfer on req_ carries one 32-element block of 4-bit weights and int8 activations.
// Four lanes form the exact integer dot product, which is scaled by the fp32-rounded product of
// the fp16 and fp32 block scales and added to an fp32 row accumulator with a single
// nearest-even rounding. A block flagged last_block delivers the row sum on rsp_ and clears the
// accumulator. After a transfer req_ready stays low until the block has passed the chain of lanes,
// merge, scale rounding, operand normalisation, multiply, align-add and final rounding, so a new
// block is taken only once the last one is through; both roundings go through the one shared
// normalise and round unit. A waiting row sum does not block the next block; only a second row
// end waits for rsp_ready. No clearing pass follows reset.
`default_nettype none

module q4_block_row_dot_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_weights_lo,
   input  wire logic [63:0] req_weights_hi,
   input  wire logic [63:0] req_acts_0,
   input  wire logic [63:0] req_acts_1,
   input  wire logic [63:0] req_acts_2,
   input  wire logic [63:0] req_acts_3,
   input  wire logic [15:0] req_weight_scale,
   input  wire logic [31:0] req_act_scale,
   input  wire logic        req_last_block,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_row_sum
);
   import q4brd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LANE, ST_MERGE, ST_WAIT1, ST_PREP, ST_MUL, ST_ADD, ST_FGO, ST_WAIT2, ST_DONE
   } state_type;

   typedef struct packed {
      logic [SIG_W-1:0] sig;
      exp_type          lsb;
   } norm_type;

   // normalise an fp32 pattern to a significand with its top bit set
   function automatic norm_type norm_f32(input logic [31:0] b);
      logic [SIG_W-1:0] s;
      logic [4:0]       lz;
      norm_type         n;
      s  = {1'b0, b[22:0]};
      lz = lzc24(s);
      if (b[30:23] != 8'b0) begin
         n.sig = {1'b1, b[22:0]};
         n.lsb = exp_type'({4'b0, b[30:23]}) - exp_type'(F32_BIAS_LSB);
      end else begin
         n.sig = s << lz;
         n.lsb = exp_type'(F32_MIN_LSB) - exp_type'({7'b0, lz});
      end
      return n;
   endfunction

   state_type state_ff;

   // block payload
   logic [63:0] wlo_ff, whi_ff;
   logic [63:0] acts_ff [NUM_LANES];
   logic [15:0] ws_ff;
   logic [31:0] as_ff;
   logic        last_ff;

   // scale product
   logic [HSIG_W+SIG_W-1:0] mm_ff, mm_in;
   exp_type                 mlsb_ff, mlsb_in;
   logic                    msign_ff, msign_in;
   logic                    dspec_ff, dspec_in;
   logic [31:0]             dspec_bits_ff, dspec_bits_in;

   // lanes and merge
   logic [NIB_W*LANE_LEN-1:0]  lane_nib [NUM_LANES];
   logic signed [PART_W-1:0]   part [NUM_LANES];
   logic signed [DOT_W-1:0]    dot_ff, dot_in;

   // fused add operands
   logic [SIG_W-1:0]  dsig_ff, dsig_in;
   exp_type           dlsb_ff, dlsb_in;
   logic [DMAG_W-1:0] dotn_ff, dotn_in;
   exp_type           dotlsb_ff, dotlsb_in;
   logic [SIG_W-1:0]  asig_ff, asig_in;
   exp_type           alsb_ff, alsb_in;
   logic              psign_ff, psign_in, asign_ff, asign_in, azero_ff, azero_in;
   logic              fspec_ff, fspec_in;
   logic [31:0]       fbits_ff, fbits_in;
   logic [PMAG_W-1:0] pmag_ff, pmag_in;
   exp_type           lp_ff, lp_in, la_ff, la_in;
   logic [MAG_W-1:0]  r_ff, r_in;
   exp_type           lw_ff, lw_in;
   logic              rsign_ff, rsign_in;

   logic [31:0] acc_ff;
   logic [31:0] res;
   logic        rsp_valid_ff;
   logic [31:0] rsp_row_sum_ff;

   rnd_req_type rnd_req;
   logic        rnd_go;
   logic [31:0] rnd_result;

   // route nibbles: low nibbles are elements 0-15, high nibbles 16-31
   always_comb begin
      for (int j = 0; j < LANE_LEN; j++) begin
         lane_nib[0][NIB_W*j +: NIB_W] = wlo_ff[8*j +: NIB_W];
         lane_nib[1][NIB_W*j +: NIB_W] = whi_ff[8*j +: NIB_W];
         lane_nib[2][NIB_W*j + NIB_W-1 -: NIB_W] = wlo_ff[8*j + 7 -: NIB_W];
         lane_nib[3][NIB_W*j + NIB_W-1 -: NIB_W] = whi_ff[8*j + 7 -: NIB_W];
      end
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      q4brd_lane u_lane (
         .clock   (clock),
         .load    (state_ff == ST_LANE),
         .nibbles (lane_nib[g]),
         .acts    (acts_ff[g]),
         .partial (part[g])
      );
   end

   // unpack both scales, classify and multiply the significands
   always_comb begin
      logic [4:0]        eh;
      logic [7:0]        ea;
      logic              hnan, hinf, hzero, anan, ainf, azero;
      logic [HSIG_W-1:0] sigh;
      logic [SIG_W-1:0]  siga;
      exp_type           hlsb, alsb;
      eh    = ws_ff[14:10];
      ea    = as_ff[30:23];
      hnan  = (eh == F16_EMAX) && (ws_ff[9:0] != '0);
      hinf  = (eh == F16_EMAX) && (ws_ff[9:0] == '0);
      hzero = (eh == 5'b0) && (ws_ff[9:0] == '0);
      anan  = (ea == F32_EMAX) && (as_ff[22:0] != '0);
      ainf  = (ea == F32_EMAX) && (as_ff[22:0] == '0);
      azero = (ea == 8'b0) && (as_ff[22:0] == '0);
      sigh  = {(eh != 5'b0), ws_ff[9:0]};
      siga  = {(ea != 8'b0), as_ff[22:0]};
      hlsb  = exp_type'({7'b0, (eh != 5'b0) ? eh : 5'd1}) - exp_type'(F16_BIAS_LSB);
      alsb  = exp_type'({4'b0, (ea != 8'b0) ? ea : 8'd1}) - exp_type'(F32_BIAS_LSB);
      mm_in    = sigh * siga;
      mlsb_in  = hlsb + alsb;
      msign_in = ws_ff[15] ^ as_ff[31];
      dspec_in = 1'b1;
      priority if (hnan || anan || (hinf && azero) || (ainf && hzero)) begin
         dspec_bits_in = CANON_NAN;
      end else if (hinf || ainf) begin
         dspec_bits_in = {msign_in, F32_INF};
      end else if (hzero || azero) begin
         dspec_bits_in = {msign_in, 31'b0};
      end else begin
         dspec_in      = 1'b0;
         dspec_bits_in = {msign_in, 31'b0};
      end
   end

   // merge the four lane sums
   always_comb begin
      dot_in = '0;
      for (int k = 0; k < NUM_LANES; k++) dot_in = dot_in + DOT_W'(part[k]);
   end

   // share the round unit between the scale product and the fused add
   assign rnd_go  = (state_ff == ST_MERGE) || (state_ff == ST_FGO);
   always_comb begin
      if (state_ff == ST_FGO) begin
         rnd_req.mag  = r_ff;
         rnd_req.lsb  = lw_ff;
         rnd_req.sign = rsign_ff;
      end else begin
         rnd_req.mag  = MAG_W'(mm_ff);
         rnd_req.lsb  = mlsb_ff;
         rnd_req.sign = msign_ff;
      end
   end

   q4brd_round u_round (
      .clock  (clock),
      .go     (rnd_go),
      .req    (rnd_req),
      .result (rnd_result)
   );

   // classify and normalise the scale, the dot product and the accumulator
   always_comb begin
      logic [31:0]       dbits;
      logic              dnan, dinf, dzero, anan, ainf, dot0, neg;
      logic [DOT_W-1:0]  dmag;
      logic [4:0]        lzd;
      logic              pzero;
      norm_type          dn, an;
      dbits = dspec_ff ? dspec_bits_ff : rnd_result;
      dnan  = (dbits[30:23] == F32_EMAX) && (dbits[22:0] != '0);
      dinf  = (dbits[30:23] == F32_EMAX) && (dbits[22:0] == '0);
      dzero = (dbits[30:0] == '0);
      anan  = (acc_ff[30:23] == F32_EMAX) && (acc_ff[22:0] != '0);
      ainf  = (acc_ff[30:23] == F32_EMAX) && (acc_ff[22:0] == '0);
      azero_in = (acc_ff[30:0] == '0);
      dot0  = (dot_ff == '0);
      neg   = dot_ff[DOT_W-1];
      dmag  = neg ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);
      lzd   = lzc24({dmag[DMAG_W-1:0], 8'b0});
      dn    = norm_f32(dbits);
      an    = norm_f32(acc_ff);
      dsig_in   = dn.sig;
      dlsb_in   = dn.lsb;
      asig_in   = an.sig;
      alsb_in   = an.lsb;
      dotn_in   = dmag[DMAG_W-1:0] << lzd;
      dotlsb_in = -exp_type'({7'b0, lzd});
      psign_in  = dbits[31] ^ neg;
      asign_in  = acc_ff[31];
      pzero     = dzero || dot0;
      fspec_in  = 1'b1;
      priority if (dnan || anan || (dinf && dot0) || (dinf && ainf && (psign_in != asign_in)))
      begin
         fbits_in = CANON_NAN;
      end else if (dinf) begin
         fbits_in = {psign_in, F32_INF};
      end else if (ainf) begin
         fbits_in = {asign_in, F32_INF};
      end else if (pzero && azero_in) begin
         fbits_in = {psign_in & asign_in, 31'b0};
      end else if (pzero) begin
         fbits_in = acc_ff;
      end else begin
         fspec_in = 1'b0;
         fbits_in = acc_ff;
      end
   end

   // form the exact product and the window exponents
   assign pmag_in = dsig_ff * dotn_ff;
   assign lp_in   = dlsb_ff + dotlsb_ff - exp_type'(PMAG_W);
   assign la_in   = alsb_ff - exp_type'(WIN_W - SIG_W);

   // align the smaller window, fold shifted-out bits into the lsb, add or subtract
   always_comb begin
      logic [WIN_W-1:0] pwin, awin, xw, yw0, yw;
      logic             xs, ys, p_big, st;
      exp_type          diff, sh_abs;
      logic [6:0]       sh;
      logic [MAG_W-1:0] d1;
      pwin   = {pmag_ff, (WIN_W-PMAG_W)'(0)};
      awin   = {asig_ff, (WIN_W-SIG_W)'(0)};
      diff   = lp_ff - la_ff;
      p_big  = !diff[EXP_W-1];
      sh_abs = p_big ? diff : -diff;
      sh     = (sh_abs > exp_type'(SHIFT_MAX)) ? 7'(SHIFT_MAX) : sh_abs[6:0];
      if (azero_ff) begin
         xw = pwin; yw0 = '0; xs = psign_ff; ys = psign_ff; lw_in = lp_ff;
      end else if (p_big) begin
         xw = pwin; yw0 = awin; xs = psign_ff; ys = asign_ff; lw_in = lp_ff;
      end else begin
         xw = awin; yw0 = pwin; xs = asign_ff; ys = psign_ff; lw_in = la_ff;
      end
      st = |(yw0 & ~({WIN_W{1'b1}} << sh));
      yw = yw0 >> sh;
      yw[0] = yw[0] | st;
      d1 = {1'b0, xw} - {1'b0, yw};
      if (xs == ys) begin
         r_in     = {1'b0, xw} + {1'b0, yw};
         rsign_in = xs;
      end else if (d1[MAG_W-1]) begin
         r_in     = {1'b0, yw} - {1'b0, xw};
         rsign_in = ys;
      end else begin
         r_in     = d1;
         rsign_in = (d1 == '0) ? 1'b0 : xs;
      end
   end

   assign res = fspec_ff ? fbits_ff : rnd_result;

   // sequencer, accumulator and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         // drop a taken row sum unless a new one is loaded in the same cycle
         if (rsp_valid_ff && rsp_ready && !(state_ff == ST_DONE && last_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  wlo_ff     <= req_weights_lo;
                  whi_ff     <= req_weights_hi;
                  acts_ff[0] <= req_acts_0;
                  acts_ff[1] <= req_acts_1;
                  acts_ff[2] <= req_acts_2;
                  acts_ff[3] <= req_acts_3;
                  ws_ff      <= req_weight_scale;
                  as_ff      <= req_act_scale;
                  last_ff    <= req_last_block;
                  state_ff   <= ST_LANE;
               end
            end
            ST_LANE: begin
               mm_ff         <= mm_in;
               mlsb_ff       <= mlsb_in;
               msign_ff      <= msign_in;
               dspec_ff      <= dspec_in;
               dspec_bits_ff <= dspec_bits_in;
               state_ff      <= ST_MERGE;
            end
            ST_MERGE: begin
               dot_ff   <= dot_in;
               state_ff <= ST_WAIT1;
            end
            ST_WAIT1: state_ff <= ST_PREP;
            ST_PREP: begin
               dsig_ff   <= dsig_in;
               dlsb_ff   <= dlsb_in;
               dotn_ff   <= dotn_in;
               dotlsb_ff <= dotlsb_in;
               asig_ff   <= asig_in;
               alsb_ff   <= alsb_in;
               psign_ff  <= psign_in;
               asign_ff  <= asign_in;
               azero_ff  <= azero_in;
               fspec_ff  <= fspec_in;
               fbits_ff  <= fbits_in;
               state_ff  <= ST_MUL;
            end
            ST_MUL: begin
               pmag_ff  <= pmag_in;
               lp_ff    <= lp_in;
               la_ff    <= la_in;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               r_ff     <= r_in;
               lw_ff    <= lw_in;
               rsign_ff <= rsign_in;
               state_ff <= ST_FGO;
            end
            ST_FGO:   state_ff <= ST_WAIT2;
            ST_WAIT2: state_ff <= ST_DONE;
            ST_DONE: begin
               if (!(last_ff && rsp_valid_ff && !rsp_ready)) begin
                  if (last_ff) begin
                     acc_ff         <= '0;
                     rsp_row_sum_ff <= res;
                     rsp_valid_ff   <= 1'b1;
                  end else begin
                     acc_ff <= res;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_row_sum = rsp_row_sum_ff;

endmodule

`default_nettype wire
